// ===== rtl/wildcard_exclude_table_match_defines.svh =====
// Assertion macros for the wildcard exclude table
`ifndef WILDCARD_EXCLUDE_TABLE_MATCH_DEFINES_SVH
`define WILDCARD_EXCLUDE_TABLE_MATCH_DEFINES_SVH
`ifndef SYNTHESIS
`define WETM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WETM_ASSERT(label, clk, rst_n, prop, msg)
`define WETM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/wetm_pkg.sv =====
`default_nettype none
package wetm_pkg;
  localparam int unsigned MaxPatterns = 16;
  localparam int unsigned PatLen = 32;
  localparam int unsigned NameLen = 64;
  localparam int unsigned SlotW = (MaxPatterns > 1) ? $clog2(MaxPatterns) : 1;
  localparam int unsigned CntW = $clog2(MaxPatterns + 1);
  localparam int unsigned PposW = $clog2(PatLen);
  localparam int unsigned PlenW = $clog2(PatLen + 1);
  localparam int unsigned NposW = $clog2(NameLen);
  localparam int unsigned NlenW = $clog2(NameLen + 1);
  localparam int unsigned PatDepth = MaxPatterns * PatLen;
  localparam int unsigned PatAw = $clog2(PatDepth);
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] ChAny = 8'h3f;
  localparam logic [7:0] ChStar = 8'h2a;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StPatLong = 2'd2;
  localparam logic [1:0] StNameLong = 2'd3;

  typedef struct packed {
    logic             do_match;
    logic [1:0]       status;
    logic [NlenW-1:0] name_len;
    logic [CntW-1:0]  pat_cnt;
  } job_t;
endpackage
`default_nettype wire

// ===== rtl/wetm_ram.sv =====
`default_nettype none
module wetm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/wetm_front.sv =====
`default_nettype none
module wetm_front import wetm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic             op_i,
  input  wire logic [7:0]       character_i,
  input  wire logic             last_i,
  input  wire logic             name_lock_i,
  output logic                  pat_we_o,
  output logic [PatAw-1:0]      pat_waddr_o,
  output logic                  len_we_o,
  output logic [SlotW-1:0]      len_slot_o,
  output logic [PlenW-1:0]      len_val_o,
  output logic                  name_we_o,
  output logic [NposW-1:0]      name_waddr_o,
  output logic                  job_push_o,
  output job_t                  job_o
);
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PlenW-1:0] lpos_q, lpos_d;
  logic [1:0]       lovf_q, lovf_d;
  logic [NlenW-1:0] nlen_q, nlen_d;
  logic             novf_q, novf_d;
  logic [1:0]       ovf_now;
  logic             nfull;

  always_comb begin
    cnt_d = cnt_q;
    lpos_d = lpos_q;
    lovf_d = lovf_q;
    nlen_d = nlen_q;
    novf_d = novf_q;
    pat_we_o = 1'b0;
    len_we_o = 1'b0;
    name_we_o = 1'b0;
    job_push_o = 1'b0;
    job_o = '0;
    ovf_now = lovf_q;
    nfull = (nlen_q >= NlenW'(NameLen));
    if (cnt_q >= CntW'(MaxPatterns)) begin
      ovf_now = StFull;
    end else if (lovf_q == StOk && lpos_q >= PlenW'(PatLen)) begin
      ovf_now = StPatLong;
    end
    if (take_i && !op_i) begin
      lovf_d = ovf_now;
      if (ovf_now == StOk) begin
        pat_we_o = 1'b1;
        lpos_d = lpos_q + PlenW'(1);
      end
      if (last_i) begin
        job_push_o = 1'b1;
        job_o.status = ovf_now;
        if (ovf_now == StOk) begin
          len_we_o = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end
        lpos_d = '0;
        lovf_d = StOk;
      end
    end
    if (take_i && op_i) begin
      if (nfull) begin
        novf_d = 1'b1;
      end else begin
        name_we_o = 1'b1;
        nlen_d = nlen_q + NlenW'(1);
      end
      if (last_i) begin
        job_push_o = 1'b1;
        job_o.do_match = !(nfull || novf_q);
        job_o.status = (nfull || novf_q) ? StNameLong : StOk;
        job_o.name_len = nfull ? nlen_q : nlen_q + NlenW'(1);
        job_o.pat_cnt = cnt_q;
        nlen_d = '0;
        novf_d = 1'b0;
      end
    end
  end

  assign pat_waddr_o = PatAw'(cnt_q[SlotW-1:0] * PatLen) + PatAw'(lpos_q[PposW-1:0]);
  assign len_slot_o = cnt_q[SlotW-1:0];
  assign len_val_o = lpos_d == '0 ? lpos_q + PlenW'(pat_we_o) : lpos_q;
  assign name_waddr_o = nlen_q[NposW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      lpos_q <= '0;
      lovf_q <= StOk;
      nlen_q <= '0;
      novf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      lpos_q <= lpos_d;
      lovf_q <= lovf_d;
      if (!name_lock_i || !(take_i && op_i)) begin
        nlen_q <= nlen_d;
        novf_q <= novf_d;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wetm_back.sv =====
`default_nettype none
`include "wildcard_exclude_table_match_defines.svh"
module wetm_back import wetm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  input  job_t                  job_i,
  output logic                  job_pop_o,
  output logic                  busy_o,
  input  wire logic             len_we_i,
  input  wire logic [SlotW-1:0] len_slot_i,
  input  wire logic [PlenW-1:0] len_val_i,
  output logic [PatAw-1:0]      pat_raddr_o,
  input  wire logic [7:0]       pat_rdata_i,
  output logic [NposW-1:0]      name_raddr_o,
  input  wire logic [7:0]       name_rdata_i,
  output logic                  done_o,
  output logic                  excluded_o,
  output logic [1:0]            status_o
);
  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CMP} state_e;

  state_e           st_q;
  logic [PlenW-1:0] plen_q [MaxPatterns];
  logic [CntW-1:0]  slot_q, cnt_q;
  logic [NlenW-1:0] nlen_q, ni_q, sn_q;
  logic [PlenW-1:0] pi_q, sp_q, plen_cur;
  logic             hs_q;
  logic [PlenW-1:0] pi_n;
  logic [NlenW-1:0] ni_n;

  assign plen_cur = plen_q[slot_q[SlotW-1:0]];
  assign busy_o = (st_q != S_IDLE);
  assign job_pop_o = (st_q == S_IDLE) && job_valid_i;
  assign pat_raddr_o = PatAw'(slot_q[SlotW-1:0] * PatLen) + PatAw'(pi_n[PposW-1:0]);
  assign name_raddr_o = ni_n[NposW-1:0];

  logic pin, nin, is_star, hit;
  always_comb begin
    pin = pi_q < plen_cur;
    nin = ni_q < nlen_q;
    is_star = pin && pat_rdata_i == ChStar;
    hit = pin && (pat_rdata_i == ChAny || pat_rdata_i == name_rdata_i);
    pi_n = pi_q;
    ni_n = ni_q;
    if (st_q == S_CMP) begin
      if (nin) begin
        if (is_star) begin
          pi_n = pi_q + PlenW'(1);
        end else if (hit) begin
          pi_n = pi_q + PlenW'(1);
          ni_n = ni_q + NlenW'(1);
        end else if (hs_q) begin
          pi_n = sp_q + PlenW'(1);
          ni_n = sn_q + NlenW'(1);
        end
      end else if (is_star) begin
        pi_n = pi_q + PlenW'(1);
      end
    end else begin
      pi_n = '0;
      ni_n = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      done_o <= 1'b0;
      excluded_o <= 1'b0;
      status_o <= StOk;
      for (int i = 0; i < MaxPatterns; i++) plen_q[i] <= '0;
    end else begin
      done_o <= 1'b0;
      if (len_we_i) plen_q[len_slot_i] <= len_val_i;
      unique case (st_q)
        S_IDLE: begin
          if (job_valid_i) begin
            excluded_o <= 1'b0;
            status_o <= job_i.status;
            nlen_q <= job_i.name_len;
            cnt_q <= job_i.pat_cnt;
            slot_q <= '0;
            if (!job_i.do_match || job_i.pat_cnt == '0) begin
              done_o <= 1'b1;
            end else begin
              st_q <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          pi_q <= '0;
          ni_q <= '0;
          hs_q <= 1'b0;
          st_q <= S_CMP;
        end
        S_CMP: begin
          pi_q <= pi_n;
          ni_q <= ni_n;
          if (nin && is_star) begin
            hs_q <= 1'b1;
            sp_q <= pi_q;
            sn_q <= ni_q;
          end else if (nin && !hit && hs_q) begin
            sn_q <= sn_q + NlenW'(1);
          end
          if ((nin && !is_star && !hit && !hs_q) || (!nin && !is_star)) begin
            if (!nin && pi_q == plen_cur) begin
              excluded_o <= 1'b1;
              done_o <= 1'b1;
              st_q <= S_IDLE;
            end else if (slot_q + CntW'(1) >= cnt_q) begin
              done_o <= 1'b1;
              st_q <= S_IDLE;
            end else begin
              slot_q <= slot_q + CntW'(1);
              st_q <= S_FETCH;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `WETM_ASSERT_NEXT(a_pop_idle, clk_i, rst_ni, job_pop_o, busy_o || done_o, "pop not served")
  `WETM_ASSERT(a_exc_ok, clk_i, rst_ni, !(done_o && excluded_o) || status_o == StOk, "bad status")
  `WETM_ASSERT(a_slot, clk_i, rst_ni, !busy_o || slot_q < cnt_q, "slot out of range")
endmodule
`default_nettype wire

// ===== rtl/wetm_queue.sv =====
`default_nettype none
module wetm_queue import wetm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      data_i,
  input  wire logic pop_i,
  output logic      valid_o,
  output logic      full_o,
  output job_t      data_o
);
  job_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] n_q;

  assign valid_o = n_q != '0;
  assign full_o = n_q == 2'(QDepth);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      n_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= data_i;
        wp_q <= ~wp_q;
      end
      if (pop_i) rp_q <= ~rp_q;
      n_q <= n_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/wildcard_exclude_table_match.sv =====
// Channel  | Ports                          | Handshake
// input    | op_i, character_i, last_i      | start_i high, busy_o low
// result   | excluded_o, status_o           | done_o strobe, one cycle
// Pattern and name characters are stored at one per cycle while busy_o is low and within capacity.
// A final character queues a job; busy_o stays high from that edge until the back end
// retires it. A load, an overlong name or a name with no stored pattern strobes done_o after the
// idle back end pops its job. A match walks each pattern through a fetch state, compare steps
// (star, match, backtrack, trailing star) and a closing step; done_o rises at the last closing step.
// Reset empties the table; the receiver cannot stall results.
`default_nettype none
module wildcard_exclude_table_match import wetm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic       op_i,
  input  wire logic [7:0] character_i,
  input  wire logic       last_i,
  output logic            done_o,
  output logic            excluded_o,
  output logic [1:0]      status_o
);
  logic             take, pat_we, len_we, name_we, push, pop, qv, qf, back_busy;
  logic [PatAw-1:0] pat_wa, pat_ra;
  logic [SlotW-1:0] len_slot;
  logic [PlenW-1:0] len_val;
  logic [NposW-1:0] name_wa, name_ra;
  logic [7:0]       pat_rd, name_rd;
  job_t             job_in, job_out;

  assign busy_o = qf || back_busy || qv;
  assign take = start_i && !busy_o;

  wetm_front u_front (
    .clk_i, .rst_ni, .take_i(take), .op_i, .character_i, .last_i,
    .name_lock_i(1'b0), .pat_we_o(pat_we), .pat_waddr_o(pat_wa),
    .len_we_o(len_we), .len_slot_o(len_slot), .len_val_o(len_val),
    .name_we_o(name_we), .name_waddr_o(name_wa), .job_push_o(push), .job_o(job_in)
  );

  wetm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .pop_i(pop),
    .valid_o(qv), .full_o(qf), .data_o(job_out)
  );

  wetm_ram #(.Width(8), .Depth(PatDepth)) u_pat_ram (
    .clk_i, .we_i(pat_we), .waddr_i(pat_wa), .wdata_i(character_i),
    .raddr_i(pat_ra), .rdata_o(pat_rd)
  );

  wetm_ram #(.Width(8), .Depth(NameLen)) u_name_ram (
    .clk_i, .we_i(name_we), .waddr_i(name_wa), .wdata_i(character_i),
    .raddr_i(name_ra), .rdata_o(name_rd)
  );

  wetm_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(job_out), .job_pop_o(pop),
    .busy_o(back_busy), .len_we_i(len_we), .len_slot_i(len_slot),
    .len_val_i(len_val), .pat_raddr_o(pat_ra), .pat_rdata_i(pat_rd),
    .name_raddr_o(name_ra), .name_rdata_i(name_rd),
    .done_o, .excluded_o, .status_o
  );
endmodule
`default_nettype wire
